// File: rtl/obb_pkg.sv
// Package: widths and constants for the box face-axis overlap test.
`timescale 1ns / 1ps
package obb_pkg;
   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int FIELD_WIDTH = 48;
   localparam int ROT_EPSILON = 1;
   localparam int POS_FRAC = 4;
endpackage

// File: rtl/obb_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
interface obb_req_if #(parameter int FW = 48);
   logic          valid;
   logic          ready;
   logic [FW-1:0] a_center;
   logic [FW-1:0] a_half_size;
   logic [FW-1:0] a_axis_u;
   logic [FW-1:0] a_axis_v;
   logic [FW-1:0] a_axis_w;
   logic [FW-1:0] b_center;
   logic [FW-1:0] b_half_size;
   logic [FW-1:0] b_axis_u;
   logic [FW-1:0] b_axis_v;
   logic [FW-1:0] b_axis_w;
   modport source (output valid, a_center, a_half_size, a_axis_u, a_axis_v, a_axis_w,
                   b_center, b_half_size, b_axis_u, b_axis_v, b_axis_w, input ready);
   modport sink (input valid, a_center, a_half_size, a_axis_u, a_axis_v, a_axis_w,
                 b_center, b_half_size, b_axis_u, b_axis_v, b_axis_w, output ready);
endinterface

interface obb_rsp_if;
   logic valid;
   logic ready;
   logic boxes_overlap;
   modport source (output valid, boxes_overlap, input ready);
   modport sink (input valid, boxes_overlap, output ready);
endinterface

// File: rtl/obb_rot.sv
// Stage pair 1-2: products for rotation and centre projections, then sums and biased magnitudes.
`timescale 1ns / 1ps
module obb_rot #(
   parameter int CW = 16,
   parameter int PW = 2 * CW + 2
) (
   input  logic                 clock,
   input  logic                 en1,
   input  logic                 en2,
   input  logic signed [CW-1:0] ax   [3][3],
   input  logic signed [CW-1:0] bx   [3][3],
   input  logic signed [CW:0]   d    [3],
   output logic        [PW-1:0] rabs [3][3],
   output logic        [PW-1:0] pca  [3],
   output logic        [PW-1:0] pcb  [3]
);
   import obb_pkg::*;
   localparam int AF = CW - 2;
   localparam int MW = 2 * CW + 1;
   logic signed [MW-1:0] rp_ff [3][3][3];
   logic signed [MW-1:0] ap_ff [3][3];
   logic signed [MW-1:0] bp_ff [3][3];
   logic        [PW-1:0] rabs_ff [3][3];
   logic        [PW-1:0] pca_ff [3];
   logic        [PW-1:0] pcb_ff [3];

   function automatic logic [PW-1:0] mag3(input logic signed [MW-1:0] p0,
                                          input logic signed [MW-1:0] p1,
                                          input logic signed [MW-1:0] p2);
      logic signed [PW:0] s;
      s = $signed({{(PW+1-MW){p0[MW-1]}}, p0}) + $signed({{(PW+1-MW){p1[MW-1]}}, p1})
        + $signed({{(PW+1-MW){p2[MW-1]}}, p2});
      return s[PW] ? PW'(-s) : s[PW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) begin
               for (int j = 0; j < 3; j++)
                  rp_ff[i][j][k] <= MW'(ax[i][k] * bx[j][k]);
               ap_ff[i][k] <= MW'(d[k] * ax[i][k]);
               bp_ff[i][k] <= MW'(d[k] * bx[i][k]);
            end
      end
      if (en2) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
               rabs_ff[i][j] <= ((mag3(rp_ff[i][j][0], rp_ff[i][j][1], rp_ff[i][j][2])
                                  + PW'(1 << (AF - 1))) >> AF) + PW'(ROT_EPSILON);
            pca_ff[i] <= mag3(ap_ff[i][0], ap_ff[i][1], ap_ff[i][2]);
            pcb_ff[i] <= mag3(bp_ff[i][0], bp_ff[i][1], bp_ff[i][2]);
         end
      end
   end
   assign rabs = rabs_ff;
   assign pca  = pca_ff;
   assign pcb  = pcb_ff;
endmodule

// File: rtl/obb_cmp.sv
// Stage pair 3-4: radius products, then radius sums and separation compares.
`timescale 1ns / 1ps
module obb_cmp #(
   parameter int CW = 16,
   parameter int PW = 2 * CW + 2
) (
   input  logic                 clock,
   input  logic                 en3,
   input  logic                 en4,
   input  logic signed [CW-1:0] ea   [3],
   input  logic signed [CW-1:0] eb   [3],
   input  logic        [PW-1:0] rabs [3][3],
   input  logic        [PW-1:0] pca  [3],
   input  logic        [PW-1:0] pcb  [3],
   output logic                 overlap
);
   import obb_pkg::*;
   localparam int AF = CW - 2;
   localparam int SW = 2 * CW + 6;
   logic signed [SW-1:0] pa_ff [3][3];
   logic signed [SW-1:0] pb_ff [3][3];
   logic signed [SW-1:0] ra_ff [3];
   logic signed [SW-1:0] rb_ff [3];
   logic        [PW-1:0] ca_ff [3];
   logic        [PW-1:0] cb_ff [3];
   logic                 ov_ff;
   logic                 sep;

   // |R| reaches three times full scale for non-unit axes, so keep CW+2 bits
   always_ff @(posedge clock) begin
      if (en3) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pa_ff[i][j] <= SW'(eb[j] * $signed({1'b0, rabs[i][j][CW+1:0]}));
               pb_ff[i][j] <= SW'(ea[j] * $signed({1'b0, rabs[j][i][CW+1:0]}));
            end
            ra_ff[i] <= SW'($signed(ea[i])) <<< AF;
            rb_ff[i] <= SW'($signed(eb[i])) <<< AF;
            ca_ff[i] <= pca[i];
            cb_ff[i] <= pcb[i];
         end
      end
      if (en4) ov_ff <= !sep;
   end

   always_comb begin
      sep = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if ($signed({1'b0, ca_ff[i]}) > (SW+2)'(ra_ff[i]) + (SW+2)'(pa_ff[i][0])
             + (SW+2)'(pa_ff[i][1]) + (SW+2)'(pa_ff[i][2]))
            sep = 1'b1;
         if ($signed({1'b0, cb_ff[i]}) > (SW+2)'(rb_ff[i]) + (SW+2)'(pb_ff[i][0])
             + (SW+2)'(pb_ff[i][1]) + (SW+2)'(pb_ff[i][2]))
            sep = 1'b1;
      end
   end
   assign overlap = ov_ff;
endmodule

// File: rtl/obb_face_axis_overlap_test_top.sv
// Top level: four-stage pipelined face-axis overlap test for box pairs.
// Usage:
//  req channel carries one box pair per request (centres, half sizes, axes).
//  rsp channel returns boxes_overlap, 1 when no face axis separates the pair.
//  Throughput: one request per cycle while rsp ready is high, set by the
//  fully parallel multipliers in each stage.
//  Stages: rotation and centre products; sums and biased |R|; radius
//  products; radius sums and compares.
//  Stall: when rsp ready is low a valid output holds, and each stage
//  holds only while the stage after it holds; req ready is then high
//  only while a bubble can be squeezed out, so nothing is lost.
//  Reset clears the stage valid bits only; the data registers are not reset.
`timescale 1ns / 1ps
module obb_face_axis_overlap_test_top #(
   parameter int COMPONENT_WIDTH = obb_pkg::COMPONENT_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   obb_req_if.sink  req,
   obb_rsp_if.source rsp
);
   import obb_pkg::*;
   localparam int CW = COMPONENT_WIDTH;
   localparam int PW = 2 * CW + 2;
   logic [3:0] v_ff, v_in;
   logic [3:0] en;
   logic signed [CW-1:0] ax [3][3];
   logic signed [CW-1:0] bx [3][3];
   logic signed [CW:0]   d  [3];
   logic signed [CW-1:0] ea_ff [2][3];
   logic signed [CW-1:0] eb_ff [2][3];
   logic        [PW-1:0] rabs [3][3];
   logic        [PW-1:0] pca [3];
   logic        [PW-1:0] pcb [3];

   function automatic logic signed [CW-1:0] cmp(input logic [FIELD_WIDTH-1:0] w,
                                                input int k);
      logic [3*CW+FIELD_WIDTH-1:0] x;
      x = (3*CW+FIELD_WIDTH)'(w);
      return x[k*CW +: CW];
   endfunction

   always_comb begin
      en[3] = !v_ff[3] || rsp.ready;
      en[2] = !v_ff[2] || en[3];
      en[1] = !v_ff[1] || en[2];
      en[0] = !v_ff[0] || en[1];
      v_in = v_ff;
      if (en[3]) v_in[3] = v_ff[2];
      if (en[2]) v_in[2] = v_ff[1];
      if (en[1]) v_in[1] = v_ff[0];
      if (en[0]) v_in[0] = req.valid;
      for (int k = 0; k < 3; k++) begin
         ax[0][k] = cmp(req.a_axis_u, k);
         ax[1][k] = cmp(req.a_axis_v, k);
         ax[2][k] = cmp(req.a_axis_w, k);
         bx[0][k] = cmp(req.b_axis_u, k);
         bx[1][k] = cmp(req.b_axis_v, k);
         bx[2][k] = cmp(req.b_axis_w, k);
         d[k] = (CW+1)'(cmp(req.b_center, k)) - (CW+1)'(cmp(req.a_center, k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= v_in;
      for (int k = 0; k < 3; k++) begin
         if (en[0]) begin
            ea_ff[0][k] <= cmp(req.a_half_size, k);
            eb_ff[0][k] <= cmp(req.b_half_size, k);
         end
         if (en[1]) begin
            ea_ff[1][k] <= ea_ff[0][k];
            eb_ff[1][k] <= eb_ff[0][k];
         end
      end
   end

   obb_rot #(.CW(CW), .PW(PW)) u_rot (
      .clock(clock), .en1(en[0]), .en2(en[1]), .ax(ax), .bx(bx), .d(d),
      .rabs(rabs), .pca(pca), .pcb(pcb));

   obb_cmp #(.CW(CW), .PW(PW)) u_cmp (
      .clock(clock), .en3(en[2]), .en4(en[3]), .ea(ea_ff[1]), .eb(eb_ff[1]),
      .rabs(rabs), .pca(pca), .pcb(pcb), .overlap(rsp.boxes_overlap));

   assign req.ready = en[0];
   assign rsp.valid = v_ff[3];
endmodule

// File: tb/sv/obb_face_axis_overlap_test_top_tb.sv
// Testbench: face-axis overlap test for box pairs, checked against a built-in predictor.
`timescale 1ns / 1ps
module obb_face_axis_overlap_test_top_tb;
   localparam int CW = obb_pkg::COMPONENT_WIDTH_DEF;
   localparam int FW = obb_pkg::FIELD_WIDTH;
   localparam int AXIS_FRAC = CW - 2;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 60;
   localparam logic [15:0] ONE_Q14 = 16'h4000;

   typedef logic [FW-1:0] vec_type;
   typedef struct packed {
      vec_type ca, ea, au, av, aw, cb, eb, bu, bv, bw;
   } pair_type;
   typedef enum int {SHAPED, RAW} mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   obb_req_if #(.FW(FW)) req_if ();
   obb_rsp_if rsp_if ();

   obb_face_axis_overlap_test_top #(.COMPONENT_WIDTH(CW)) u_dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   bit   overlap_q[$];
   int   mismatch_count = 0;
   int   idle_cycles = 0;
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   bit   hold_active = 1'b0;
   bit   timed_out = 0;
   event hold_start_ev;

   function automatic longint lane(vec_type w, int k);
      return longint'($signed(w[k*CW +: CW]));
   endfunction

   function automatic longint dot(vec_type a, vec_type b);
      return lane(a, 0) * lane(b, 0) + lane(a, 1) * lane(b, 1) + lane(a, 2) * lane(b, 2);
   endfunction

   function automatic longint absl(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic bit predict_overlap(pair_type p);
      longint  dv[3], rabs[3][3], pc, ra, rb, ea[3], eb[3];
      vec_type ax[3], bx[3];
      bit      ov;
      ov = 1'b1;
      ax = '{p.au, p.av, p.aw};
      bx = '{p.bu, p.bv, p.bw};
      for (int k = 0; k < 3; k++) begin
         dv[k] = lane(p.cb, k) - lane(p.ca, k);
         ea[k] = lane(p.ea, k);
         eb[k] = lane(p.eb, k);
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            rabs[i][j] = ((absl(dot(ax[i], bx[j])) + (64'sd1 <<< (AXIS_FRAC - 1)))
                          >>> AXIS_FRAC) + obb_pkg::ROT_EPSILON;
      for (int i = 0; i < 3; i++) begin
         pc = absl(dv[0] * lane(ax[i], 0) + dv[1] * lane(ax[i], 1) + dv[2] * lane(ax[i], 2));
         ra = ea[i] <<< AXIS_FRAC;
         rb = eb[0] * rabs[i][0] + eb[1] * rabs[i][1] + eb[2] * rabs[i][2];
         if (pc > ra + rb) ov = 1'b0;
         pc = absl(dv[0] * lane(bx[i], 0) + dv[1] * lane(bx[i], 1) + dv[2] * lane(bx[i], 2));
         ra = ea[0] * rabs[0][i] + ea[1] * rabs[1][i] + ea[2] * rabs[2][i];
         rb = eb[i] <<< AXIS_FRAC;
         if (pc > ra + rb) ov = 1'b0;
      end
      return ov;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // receiver side: random stalls, long hold-off while hold_active
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_active) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // long receiver hold-off, counted here
   always begin
      @(hold_start_ev);
      hold_active <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      hold_active <= 1'b0;
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (overlap_q.size() == 0)
            report_mismatch("response with no request outstanding");
         else if (rsp_if.boxes_overlap !== overlap_q[0])
            report_mismatch($sformatf("boxes_overlap got %b expected %b",
                                      rsp_if.boxes_overlap, overlap_q[0]));
         if (overlap_q.size() != 0) void'(overlap_q.pop_front());
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_pair(pair_type p);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         @(posedge clock);
         req_if.valid <= 1'b0;
      end
      @(posedge clock);
      req_if.valid       <= 1'b1;
      req_if.a_center    <= p.ca;
      req_if.a_half_size <= p.ea;
      req_if.a_axis_u    <= p.au;
      req_if.a_axis_v    <= p.av;
      req_if.a_axis_w    <= p.aw;
      req_if.b_center    <= p.cb;
      req_if.b_half_size <= p.eb;
      req_if.b_axis_u    <= p.bu;
      req_if.b_axis_v    <= p.bv;
      req_if.b_axis_w    <= p.bw;
      overlap_q = {overlap_q, predict_overlap(p)};
      do @(negedge clock); while (!req_if.ready);
   endtask

   task automatic end_stream();
      @(posedge clock);
      req_if.valid <= 1'b0;
   endtask

   function automatic vec_type pack3(int x, int y, int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   function automatic vec_type rand_vec();
      return FW'({$urandom(), $urandom()});
   endfunction

   function automatic logic [15:0] small_pos();
      return 16'($signed($urandom_range(1600)) - 800);
   endfunction

   // random rotation-ish axes: permuted, signed near-unit with jitter; RAW mode fills every field at random
   function automatic pair_type random_pair(mode_type mode);
      pair_type p;
      logic [15:0] j[3];
      if (mode == RAW) begin
         p.ca = rand_vec();
         p.ea = rand_vec();
         p.au = rand_vec();
         p.av = rand_vec();
         p.aw = rand_vec();
         p.cb = rand_vec();
         p.eb = rand_vec();
         p.bu = rand_vec();
         p.bv = rand_vec();
         p.bw = rand_vec();
         return p;
      end
      p.ca = pack3(small_pos(), small_pos(), small_pos());
      p.cb = pack3(small_pos(), small_pos(), small_pos());
      p.ea = pack3($urandom_range(400), $urandom_range(400), $urandom_range(400));
      p.eb = pack3($urandom_range(400), $urandom_range(400), $urandom_range(400));
      for (int k = 0; k < 3; k++) j[k] = 16'($signed($urandom_range(8000)) - 4000);
      p.au = pack3(ONE_Q14 - 16'(j[0] & 16'h0fff), j[1], j[2]);
      p.av = pack3(j[2], ONE_Q14 - 16'(j[1] & 16'h0fff), j[0]);
      p.aw = pack3(j[1], j[0], ($urandom_range(1) ? -ONE_Q14 : ONE_Q14));
      for (int k = 0; k < 3; k++) j[k] = 16'($signed($urandom_range(16000)) - 8000);
      p.bu = pack3(j[0], ONE_Q14 - 16'(j[1] & 16'h1fff), j[2]);
      p.bv = pack3(ONE_Q14, j[2], j[1]);
      p.bw = pack3(j[2], j[0], ONE_Q14 - 16'(j[0] & 16'h1fff));
      return p;
   endfunction

   task automatic wait_drain();
      int guard;
      guard = 0;
      while (overlap_q.size() != 0 && guard < WATCHDOG_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic test_directed();
      pair_type p;
      vec_type id_u, id_v, id_w;
      id_u = pack3(ONE_Q14, 0, 0);
      id_v = pack3(0, ONE_Q14, 0);
      id_w = pack3(0, 0, ONE_Q14);
      // unit cubes, identity axes, touching then apart along x
      p = '{pack3(0, 0, 0), pack3(16, 16, 16), id_u, id_v, id_w,
            pack3(32, 0, 0), pack3(16, 16, 16), id_u, id_v, id_w};
      send_pair(p);
      p.cb = pack3(33, 0, 0);
      send_pair(p);
      p.cb = pack3(16'hffdf, 0, 0);
      send_pair(p);
      // negative half extents
      p.cb = pack3(0, 0, 0);
      p.ea = pack3(16'hff00, 16'hff00, 16'hff00);
      send_pair(p);
      p.eb = pack3(16'hffff, 16'h8000, 16'h7fff);
      send_pair(p);
      // extreme centres and axes
      p = '{pack3(16'h8000, 16'h8000, 16'h8000), '0, pack3(16'h8000, 16'h8000, 16'h8000),
            pack3(16'h7fff, 16'h7fff, 16'h7fff), '1,
            pack3(16'h7fff, 16'h7fff, 16'h7fff), '1, '1,
            pack3(16'h8000, 16'h8000, 16'h8000), pack3(16'h7fff, 16'h8000, 16'h0001)};
      send_pair(p);
      send_pair('0);
      send_pair('1);
      p = '{default: '1};
      p.ea = '0;
      send_pair(p);
      // non-unit axes
      p = '{pack3(0, 0, 0), pack3(100, 100, 100), pack3(3, 0, 0), pack3(0, 7, 0),
            pack3(0, 0, 16'h7fff), pack3(500, 20, 16'hfff0), pack3(5, 5, 5),
            pack3(16'h2d41, 16'h2d41, 0), pack3(16'hd2bf, 16'h2d41, 0), id_w};
      send_pair(p);
      end_stream();
      wait_drain();
   endtask

   task automatic test_random(int n, int s_idle, int r_stall);
      send_idle_pct = s_idle;
      stall_pct     = r_stall;
      for (int i = 0; i < n; i++)
         send_pair(random_pair($urandom_range(9) == 0 ? RAW : SHAPED));
      end_stream();
      wait_drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      -> hold_start_ev;
      for (int i = 0; i < 40; i++) send_pair(random_pair(SHAPED));
      end_stream();
      wait_drain();
   endtask

   initial begin
      req_if.valid <= 1'b0;
      {req_if.a_center, req_if.a_half_size, req_if.a_axis_u, req_if.a_axis_v,
       req_if.a_axis_w, req_if.b_center, req_if.b_half_size, req_if.b_axis_u,
       req_if.b_axis_v, req_if.b_axis_w} <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300, 0, 0);
      test_random(300, 59, 0);
      test_random(300, 0, 59);
      test_random(260, 29, 29);
      test_backpressure();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && overlap_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
